### hw/rtl/lkvc_pkg.sv
// ----------------------------------------------------------------------------
// lkvc_pkg
// Shared types and constants of the LRU key/value cache.
// ----------------------------------------------------------------------------
package lkvc_pkg;

	localparam int ENTRIES    = 16;
	localparam int KEY_BITS   = 32;
	localparam int VALUE_BITS = 32;
	localparam int IDX_W      = $clog2(ENTRIES);
	localparam int CNT_W      = $clog2(ENTRIES + 1);
	localparam int OP_W       = 2;
	localparam int IN_W       = ((KEY_BITS + VALUE_BITS + 7) / 8) * 8;
	localparam int OUT_BITS   = VALUE_BITS + CNT_W;
	localparam int OUT_W      = ((OUT_BITS + 7) / 8) * 8;

	typedef enum logic [OP_W-1:0] {
		OP_GET      = 2'd0,
		OP_PUT      = 2'd1,
		OP_CONTAINS = 2'd2,
		OP_CLEAR    = 2'd3
	} op_t;

endpackage

### hw/rtl/lru_key_value_cache.sv
// ----------------------------------------------------------------------------
// lru_key_value_cache
// Fully associative key/value store with least-recently-used replacement.
// ----------------------------------------------------------------------------
// Sequence: the request is registered in the idle state; tag compare, rank
// update and value memory read happen together in the execute state, and the
// result is presented in the respond state.
// A new request is taken only in the idle state, once the previous result has
// been taken; a stalled result holds off the next request.
// Reset: asynchronous; all slots invalid, occupancy zero, capacity sixteen.
module lru_key_value_cache (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cfg_valid,
	output logic                        cfg_ready,
	input  logic [lkvc_pkg::CNT_W-1:0]  cfg_data,
	input  logic                        s_tvalid,
	output logic                        s_tready,
	input  logic [lkvc_pkg::IN_W-1:0]   s_tdata,  // key, value
	input  logic [lkvc_pkg::OP_W-1:0]   s_tuser,  // op
	output logic                        m_tvalid,
	input  logic                        m_tready,
	output logic [lkvc_pkg::OUT_W-1:0]  m_tdata,  // read_value, occupancy
	output logic                        m_tuser   // found
);
	import lkvc_pkg::*;

	typedef enum logic [1:0] {ST_IDLE, ST_EXEC, ST_RESP} state_t;

	state_t                 state_q;
	logic [CNT_W-1:0]       capacity_q;
	logic [CNT_W-1:0]       count_q;
	logic [ENTRIES-1:0]     valid_q;
	logic [KEY_BITS-1:0]    key_arr_q  [ENTRIES];
	logic [IDX_W-1:0]       rank_arr_q [ENTRIES];
	logic [VALUE_BITS-1:0]  value_mem  [ENTRIES];
	logic [VALUE_BITS-1:0]  rd_data_q;
	op_t                    op_q;
	logic [KEY_BITS-1:0]    key_q;
	logic [VALUE_BITS-1:0]  value_q;
	logic                   found_q;
	logic                   get_hit_q;

	logic [ENTRIES-1:0]     hit_vec;
	logic                   hit;
	logic [IDX_W-1:0]       hit_idx;
	logic [IDX_W-1:0]       hit_rank;
	logic [CNT_W-1:0]       cap;
	logic                   evict;
	logic [ENTRIES-1:0]     victim_vec;
	logic [ENTRIES-1:0]     valid_left;
	logic [IDX_W-1:0]       free_idx;
	logic [CNT_W-1:0]       oldest_rank;

	assign cfg_ready = 1'b1;
	assign s_tready  = (state_q == ST_IDLE);
	assign m_tvalid  = (state_q == ST_RESP);
	assign m_tuser   = found_q;
	assign m_tdata   = {{(OUT_W-OUT_BITS){1'b0}}, count_q,
		(get_hit_q ? rd_data_q : {VALUE_BITS{1'b0}})};

	always_comb begin
		cap         = (capacity_q > CNT_W'(ENTRIES)) ? CNT_W'(ENTRIES) : capacity_q;
		evict       = ((count_q + CNT_W'(1)) > cap);
		oldest_rank = count_q - CNT_W'(1);
		hit         = 1'b0;
		hit_idx     = '0;
		free_idx    = '0;
		for (int i = 0; i < ENTRIES; i++) begin
			hit_vec[i]    = valid_q[i] && (key_arr_q[i] == key_q);
			victim_vec[i] = valid_q[i] && evict &&
				({1'b0, rank_arr_q[i]} == oldest_rank);
		end
		valid_left = valid_q & ~victim_vec;
		for (int i = ENTRIES - 1; i >= 0; i--) begin
			if (hit_vec[i]) begin
				hit     = 1'b1;
				hit_idx = IDX_W'(i);
			end
			if (!valid_left[i]) begin
				free_idx = IDX_W'(i);
			end
		end
		hit_rank = rank_arr_q[hit_idx];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			capacity_q <= CNT_W'(ENTRIES);
			count_q    <= '0;
			valid_q    <= '0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				capacity_q <= cfg_data;
			end
			case (state_q)
				ST_IDLE: begin
					if (s_tvalid) begin
						op_q    <= op_t'(s_tuser);
						key_q   <= s_tdata[KEY_BITS-1:0];
						value_q <= s_tdata[KEY_BITS+VALUE_BITS-1:KEY_BITS];
						state_q <= ST_EXEC;
					end
				end
				ST_EXEC: begin
					found_q   <= (op_q != OP_CLEAR) && hit;
					get_hit_q <= (op_q == OP_GET) && hit;
					state_q   <= ST_RESP;
					if (op_q == OP_CLEAR) begin
						valid_q <= '0;
						count_q <= '0;
					end else if (hit && (op_q == OP_GET ||
						(op_q == OP_PUT && cap != '0))) begin
						for (int i = 0; i < ENTRIES; i++) begin
							if (valid_q[i] && rank_arr_q[i] < hit_rank) begin
								rank_arr_q[i] <= rank_arr_q[i] + IDX_W'(1);
							end
						end
						rank_arr_q[hit_idx] <= '0;
					end else if (!hit && op_q == OP_PUT && cap != '0) begin
						for (int i = 0; i < ENTRIES; i++) begin
							if (valid_left[i]) begin
								rank_arr_q[i] <= rank_arr_q[i] + IDX_W'(1);
							end
						end
						rank_arr_q[free_idx] <= '0;
						key_arr_q[free_idx]  <= key_q;
						valid_q              <= valid_left | (ENTRIES'(1) << free_idx);
						count_q              <= evict ? count_q : count_q + CNT_W'(1);
					end
				end
				ST_RESP: begin
					if (m_tready) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_EXEC) begin
			if (op_q == OP_PUT && cap != '0) begin
				value_mem[hit ? hit_idx : free_idx] <= value_q;
			end
			rd_data_q <= value_mem[hit_idx];
		end
	end

endmodule
